[rtl/rxsort_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rxsort_pkg
// Types, constants and the name masking function for the record sorter.
// ----------------------------------------------------------------------------
package rxsort_pkg;

  localparam int NameBytesMax = 20;
  localparam int NameBytes    = 20;
  localparam int KeyBits      = 8 * NameBytesMax;

  typedef struct packed {
    logic [63:0] name_head;
    logic [63:0] name_middle;
    logic [31:0] name_tail;
    logic [7:0]  age;
  } in_item_t;

  typedef struct packed {
    logic [63:0] sorted_name_head;
    logic [63:0] sorted_name_middle;
    logic [31:0] sorted_name_tail;
    logic [7:0]  sorted_age;
    logic        final_record;
  } out_item_t;

  localparam int RecBits = $bits(in_item_t);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_LATCH,
    ST_CMP,
    ST_WRBACK,
    ST_EMIT_RD,
    ST_EMIT_HOLD
  } state_t;

  // Zero every byte after the first zero byte and past NameBytes.
  function automatic in_item_t mask_name(in_item_t x);
    logic [KeyBits-1:0] name;
    logic               ended;
    logic [7:0]         b;
    name  = {x.name_head, x.name_middle, x.name_tail};
    ended = 1'b0;
    for (int k = 0; k < NameBytesMax; k++) begin
      b = name[KeyBits-1-8*k -: 8];
      if (k >= NameBytes || b == 8'd0) ended = 1'b1;
      if (ended) name[KeyBits-1-8*k -: 8] = 8'd0;
    end
    mask_name = x;
    {mask_name.name_head, mask_name.name_middle, mask_name.name_tail} = name;
  endfunction

endpackage
`default_nettype wire

[rtl/rxsort_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rxsort_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rxsort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

[rtl/record_exchange_sort_by_name_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// record_exchange_sort_by_name_unit
// Collects RECORD_COUNT name/age records, exchange-sorts them by name and
// sends them out in order, flagging the last record of each batch.
// ----------------------------------------------------------------------------
// Each input transfer loads one record; names are masked after the
// first zero byte on the way in. When the batch is full the input stalls
// while the sort runs and the results leave: one compare per cycle through a single
// 160-bit comparator, fed by the one read port of the record RAM, with a latch
// state and a write-back state around each outer pass. Results then leave
// one at a time, each read from the RAM and held until the output takes it.
// ----------------------------------------------------------------------------
module record_exchange_sort_by_name_unit
  import rxsort_pkg::*;
#(
  parameter int RECORD_COUNT = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int AW = $clog2(RECORD_COUNT);
  localparam logic [AW-1:0] LastIdx = AW'(RECORD_COUNT - 1);
  localparam logic [AW-1:0] PenIdx  = AW'(RECORD_COUNT - 2);

  state_t state, state_next;

  logic [AW-1:0] ld_idx;
  logic [AW-1:0] i;
  logic [AW-1:0] j;
  logic [AW-1:0] e;
  in_item_t      cur;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  in_item_t           wr_rec;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [RecBits-1:0] rd_data;
  in_item_t           rd_rec;

  logic               in_xfer;
  logic               swap;
  logic [KeyBits-1:0] cur_key;
  logic [KeyBits-1:0] rd_key;

  assign rd_rec  = in_item_t'(rd_data);
  assign in_xfer = in_valid && !in_stall;
  assign cur_key = {cur.name_head, cur.name_middle, cur.name_tail};
  assign rd_key  = {rd_rec.name_head, rd_rec.name_middle, rd_rec.name_tail};
  assign swap    = (state == ST_CMP) && (cur_key > rd_key);

  rxsort_ram #(
    .WIDTH(RecBits),
    .DEPTH(RECORD_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (RecBits'(wr_rec)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:      if (in_xfer && ld_idx == LastIdx) state_next = ST_LATCH;
      ST_LATCH:     state_next = ST_CMP;
      ST_CMP:       if (j == LastIdx) state_next = ST_WRBACK;
      ST_WRBACK:    state_next = (i == PenIdx) ? ST_EMIT_RD : ST_LATCH;
      ST_EMIT_RD:   state_next = ST_EMIT_HOLD;
      ST_EMIT_HOLD: begin
        if (!out_stall) state_next = (e == LastIdx) ? ST_LOAD : ST_EMIT_RD;
      end
      default:      state_next = ST_LOAD;
    endcase
  end

  // outputs and RAM control
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = ld_idx;
    wr_rec    = cur;
    rd_en     = 1'b0;
    rd_addr   = e;
    unique case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        wr_en    = in_valid;
        wr_rec   = mask_name(in_data);
        rd_en    = in_valid && ld_idx == LastIdx;
        rd_addr  = '0;
      end
      ST_LATCH: begin
        rd_en   = 1'b1;
        rd_addr = i + AW'(1);
      end
      ST_CMP: begin
        wr_en   = swap;
        wr_addr = j;
        rd_en   = (j != LastIdx);
        rd_addr = j + AW'(1);
      end
      ST_WRBACK: begin
        wr_en   = 1'b1;
        wr_addr = i;
        rd_en   = (i != PenIdx);
        rd_addr = i + AW'(1);
      end
      ST_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = e;
      end
      ST_EMIT_HOLD: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    out_data.sorted_name_head   = rd_rec.name_head;
    out_data.sorted_name_middle = rd_rec.name_middle;
    out_data.sorted_name_tail   = rd_rec.name_tail;
    out_data.sorted_age         = rd_rec.age;
    out_data.final_record       = (e == LastIdx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      ld_idx <= '0;
      i      <= '0;
      j      <= '0;
      e      <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_LOAD: begin
          i <= '0;
          if (in_xfer) ld_idx <= (ld_idx == LastIdx) ? '0 : ld_idx + AW'(1);
        end
        ST_LATCH:  j <= i + AW'(1);
        ST_CMP:    if (j != LastIdx) j <= j + AW'(1);
        ST_WRBACK: begin
          e <= '0;
          if (i != PenIdx) i <= i + AW'(1);
        end
        ST_EMIT_HOLD: begin
          if (!out_stall) e <= (e == LastIdx) ? '0 : e + AW'(1);
        end
        default: ;
      endcase
    end
  end

  // record held at position i during a pass
  always_ff @(posedge clk) begin
    if (state == ST_LATCH || swap) cur <= rd_rec;
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall))
    else $error("input open while output valid");

  a_last_out_reopens: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.final_record |=> !in_stall)
    else $error("input not reopened after last transfer");

  a_full_batch_stalls: assert property (@(posedge clk) disable iff (rst)
    in_xfer && ld_idx == LastIdx |=> in_stall)
    else $error("input accepted past a full batch");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    state == ST_CMP |-> j > i)
    else $error("compare pair out of order");

endmodule
`default_nettype wire

[bench/tb_record_exchange_sort_by_name_unit.sv]
// ----------------------------------------------------------------------------
// tb_record_exchange_sort_by_name_unit
// Self-checking bench for the record sorter. Batches of records go in with
// random gaps. A scoreboard masks each name, exchange-sorts every completed
// batch in the same swap order as the block, and checks each output transfer
// field by field while the output side stalls at random.
// ----------------------------------------------------------------------------
module tb_record_exchange_sort_by_name_unit;
  import rxsort_pkg::*;

  localparam int BATCH_SIZE = 8;
  localparam int KEY_W      = 160;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  bit no_gaps = 1'b0;
  int rx_left = 0;

  record_exchange_sort_by_name_unit #(
    .RECORD_COUNT(BATCH_SIZE)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  class record_sort_board;
    logic [KEY_W-1:0] key_store [BATCH_SIZE];
    logic [7:0]       age_store [BATCH_SIZE];
    int               loaded;
    int               sent;
    int               batches;
    int               checked;
    int               errors;
    out_item_t        sorted_expected [$];

    function automatic logic [KEY_W-1:0] masked_key(logic [KEY_W-1:0] raw);
      logic [KEY_W-1:0] k;
      bit               live;
      k    = '0;
      live = 1'b1;
      for (int n = 0; n < KEY_W / 8; n++) begin
        if (n >= NameBytes || raw[KEY_W-1-8*n -: 8] == 8'h00) live = 1'b0;
        if (live) k[KEY_W-1-8*n -: 8] = raw[KEY_W-1-8*n -: 8];
      end
      return k;
    endfunction

    function void load_record(in_item_t rec);
      logic [KEY_W-1:0] kt;
      logic [7:0]       at;
      out_item_t        r;
      key_store[loaded] = masked_key({rec.name_head, rec.name_middle, rec.name_tail});
      age_store[loaded] = rec.age;
      loaded++;
      sent++;
      if (loaded == BATCH_SIZE) begin
        for (int i = 0; i < BATCH_SIZE - 1; i++) begin
          for (int j = i + 1; j < BATCH_SIZE; j++) begin
            if (key_store[i] > key_store[j]) begin
              kt = key_store[i]; key_store[i] = key_store[j]; key_store[j] = kt;
              at = age_store[i]; age_store[i] = age_store[j]; age_store[j] = at;
            end
          end
        end
        for (int i = 0; i < BATCH_SIZE; i++) begin
          {r.sorted_name_head, r.sorted_name_middle, r.sorted_name_tail} = key_store[i];
          r.sorted_age   = age_store[i];
          r.final_record = (i == BATCH_SIZE - 1);
          sorted_expected.push_back(r);
        end
        loaded = 0;
        batches++;
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("MISMATCH record %0d: %s", checked, msg);
      errors++;
    endtask

    task check_sorted(out_item_t got);
      out_item_t want;
      if (sorted_expected.size() == 0) begin
        report_mismatch($sformatf("transfer with nothing pending, head=%h",
                                  got.sorted_name_head));
        return;
      end
      want = sorted_expected.pop_front();
      if (got.sorted_name_head !== want.sorted_name_head)
        report_mismatch($sformatf("name_head %h, want %h",
                                  got.sorted_name_head, want.sorted_name_head));
      if (got.sorted_name_middle !== want.sorted_name_middle)
        report_mismatch($sformatf("name_middle %h, want %h",
                                  got.sorted_name_middle, want.sorted_name_middle));
      if (got.sorted_name_tail !== want.sorted_name_tail)
        report_mismatch($sformatf("name_tail %h, want %h",
                                  got.sorted_name_tail, want.sorted_name_tail));
      if (got.sorted_age !== want.sorted_age)
        report_mismatch($sformatf("age %0d, want %0d", got.sorted_age, want.sorted_age));
      if (got.final_record !== want.final_record)
        report_mismatch($sformatf("final_record %b, want %b",
                                  got.final_record, want.final_record));
      checked++;
    endtask
  endclass

  record_sort_board sb;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t make_record(logic [KEY_W-1:0] key, logic [7:0] a);
    return {key, a};
  endfunction

  function automatic logic [KEY_W-1:0] random_key(logic [KEY_W-1:0] prev);
    logic [KEY_W-1:0] k;
    int               len;
    int               pos;
    for (int w = 0; w < KEY_W / 32; w++) k[32*w +: 32] = $urandom();
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3, 4: begin
        // short word over a tiny alphabet, junk after the terminator
        len = $urandom_range(0, 6);
        for (int n = 0; n < len; n++) k[KEY_W-1-8*n -: 8] = 8'(8'h61 + $urandom_range(0, 2));
        k[KEY_W-1-8*len -: 8] = 8'h00;
      end
      5: begin
        for (int n = 0; n < KEY_W / 8; n++) k[KEY_W-1-8*n -: 8] = 8'($urandom_range(1, 255));
      end
      6, 7: k = prev;
      default: begin
        // long shared prefix, one late byte changed
        k   = prev;
        pos = $urandom_range(8, 19);
        k[KEY_W-1-8*pos -: 8] = 8'($urandom_range(1, 255));
      end
    endcase
    return k;
  endfunction

  // Called right after a rising edge; leaves in_valid high on return.
  task automatic send_record(input in_item_t rec);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= rec;
    do @(posedge clk); while (in_stall);
    sb.load_record(rec);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_sorted(out_data);
    if (rx_left > 0) begin
      rx_left = rx_left - 1;
    end else if ($urandom_range(0, 1) == 0) begin
      out_stall <= 1'b0;
      rx_left = $urandom_range(0, 30);
    end else begin
      out_stall <= 1'b1;
      rx_left = pick_gap();
    end
  end

  initial begin
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] prev_key;
    sb       = new();
    prev_key = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty, unterminated, equal after masking, terminator at the last byte
    send_record(make_record({"bob", 136'd0}, 8'h00));
    send_record(make_record('0, 8'hFF));
    send_record(make_record({8'h00, {19{8'hA5}}}, 8'h01));
    send_record(make_record({20{8'hFF}}, 8'hFF));
    send_record(make_record({20{8'h01}}, 8'h80));
    send_record(make_record({"bob", 8'h00, {16{8'h5A}}}, 8'h7F));
    send_record(make_record({{19{8'h7E}}, 8'h00}, 8'h02));
    send_record(make_record({{19{8'hFF}}, 8'h01}, 8'h03));

    // already in order, with equal names
    send_record(make_record({"ann", 136'd0}, 8'd10));
    send_record(make_record({"ann", 136'd0}, 8'd11));
    send_record(make_record({"bea", 136'd0}, 8'd12));
    send_record(make_record({"bea", 8'h00, {16{8'h33}}}, 8'd13));
    send_record(make_record({"bea", 136'd0}, 8'd14));
    send_record(make_record({"zed", 136'd0}, 8'd15));
    send_record(make_record({"zed", 136'd0}, 8'd16));
    send_record(make_record({"zed", 136'd0}, 8'd17));

    // reverse order, keys differ only in the middle and tail words
    for (int k = 0; k < BATCH_SIZE; k++)
      send_record(make_record({{15{8'h71}}, 8'(8'h90 - k / 2), {3{8'h71}},
                               8'(8'hF0 - k % 2)}, 8'(200 + k)));

    for (int b = 0; b < 36; b++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < BATCH_SIZE; n++) begin
        key = random_key(prev_key);
        send_record(make_record(key, 8'($urandom_range(0, 255))));
        prev_key = key;
      end
    end
    in_valid <= 1'b0;

    while (sb.sorted_expected.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d records in %0d batches; checked %0d sorted records.",
             sb.sent, sb.batches, sb.checked);
    $display("Covered empty, unterminated and duplicate names with random stalls both ways.");
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[record_exchange_sort_by_name_unit.f]
rtl/rxsort_pkg.sv
rtl/rxsort_ram.sv
rtl/record_exchange_sort_by_name_unit.sv
bench/tb_record_exchange_sort_by_name_unit.sv
